@@ rtl/core/bfa_pkg.sv @@
package bfa_pkg;

	localparam int FRAME_W = 16;
	localparam int RUN_W   = 17;
	localparam int TOTAL_W = 17;

	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 17'h10000;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_FREE    = 2'd1;
	localparam logic [1:0] ACT_RESERVE = 2'd2;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_NOSPACE = 2'd1;
	localparam logic [1:0] STAT_BAD     = 2'd2;

endpackage

@@ rtl/core/bitmap_frame_allocator_top.sv @@
// First-fit page frame allocator over a usage bitmap held in one on-chip memory.
// Input channel (in_valid/in_stall) carries one request word: action, run_length
// and frame. Output channel (out_valid/out_stall) returns one word per request:
// first_frame and status. total_frames is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which it does not enforce.
// After reset the bitmap memory is swept to zero, one word a cycle, across every
// word; in_stall stays high until the sweep ends.
// Allocate scans the bitmap one memory word per cycle with a single read port.
// When no run fits, the result is raised once the scan has read the last word;
// when a run is found it is written back one word a cycle, and the result is
// raised once the last word of the run is written. Zero-length or undefined
// requests go straight to the result. Free and reserve take the word index and
// bit straight from the frame number, then read and write one word.
// One request is worked on at a time; in_stall is low only when idle. The
// result sits in an output register, so the next request can be taken while a
// result is held by out_stall; a finished result waits in place until the
// output register is free.
module bitmap_frame_allocator_top
	import bfa_pkg::*;
#(
	parameter int FRAME_COUNT = 65536,
	parameter int WORD_BITS   = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [TOTAL_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [RUN_W-1:0]   run_length,
	input  logic [FRAME_W-1:0] frame,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FRAME_W-1:0] first_frame,
	output logic [1:0]         status
);

	localparam int FB         = $clog2(FRAME_COUNT);
	localparam int CNT_W      = (FB + 1 > TOTAL_W) ? FB + 1 : TOTAL_W;
	localparam int BW         = $clog2(WORD_BITS);
	localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_SCAN    = 4'd2;
	localparam logic [3:0] S_MARK_RD = 4'd3;
	localparam logic [3:0] S_MARK_WR = 4'd4;
	localparam logic [3:0] S_FR_RD   = 4'd5;
	localparam logic [3:0] S_FR_WR   = 4'd6;
	localparam logic [3:0] S_RESP    = 4'd7;

	function automatic logic [WORD_BITS-1:0] low_mask(input logic [BW:0] n);
		logic [WORD_BITS-1:0] one;
		one = {{(WORD_BITS-1){1'b0}}, 1'b1};
		if (int'(n) >= WORD_BITS) return '1;
		return (one << n) - one;
	endfunction

	logic [WORD_BITS-1:0] bitmap_mem [WORD_COUNT];
	logic [WORD_BITS-1:0] rdata_q;

	logic [3:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [TOTAL_W-1:0] total_q;
	logic [RUN_W-1:0]   len_q;
	logic               set_q;
	logic [AW-1:0]      cur_q;
	logic [CNT_W-1:0]   base_q;
	logic [CNT_W-1:0]   run_q;
	logic [CNT_W-1:0]   st_f_q;
	logic [AW-1:0]      st_w_q;
	logic [BW-1:0]      st_b_q;
	logic [AW-1:0]      mark_w_q;
	logic [BW-1:0]      mark_b_q;
	logic [CNT_W-1:0]   left_q;
	logic [AW-1:0]      fr_w_q;
	logic [BW-1:0]      fr_b_q;
	logic [FRAME_W-1:0] res_first_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;
	logic [FRAME_W-1:0] first_q;
	logic [1:0]         status_q;

	logic                 in_accept;
	logic                 resp_load;
	logic [CNT_W-1:0]     limit_c;
	logic [CNT_W-1:0]     len_ext;
	logic [CNT_W-1:0]     rem_c;
	logic                 last_c;
	logic [WORD_BITS-1:0] vmask_c;
	logic [WORD_BITS-1:0] free_c;
	logic                 full_c;
	logic [BW:0]          top_c;
	logic [WORD_BITS-1:0] pw_c [BW+1];
	logic [WORD_BITS-1:0] win_c;
	logic [BW-1:0]        pos_c;
	logic                 len_small;
	logic [CNT_W-1:0]     need_c;
	logic [WORD_BITS-1:0] cmask_c;
	logic                 carry_hit;
	logic                 win_hit;
	logic [BW:0]          span_c;
	logic [BW:0]          take_c;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;
	logic [WORD_BITS-1:0] fr_bit_c;

	assign in_stall    = (state_q != S_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign resp_load   = (state_q == S_RESP) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign first_frame = first_q;
	assign status      = status_q;

	assign limit_c = (CNT_W'(total_q) > CNT_W'(FRAME_COUNT)) ? CNT_W'(FRAME_COUNT)
		: CNT_W'(total_q);
	assign len_ext = CNT_W'(len_q);

	always_comb begin
		rem_c     = limit_c - base_q;
		last_c    = rem_c <= CNT_W'(WORD_BITS);
		vmask_c   = last_c ? low_mask(rem_c[BW:0]) : '1;
		free_c    = ~rdata_q & vmask_c;
		full_c    = &free_c;
		top_c     = (BW+1)'(WORD_BITS);
		for (int i = 0; i < WORD_BITS; i++) begin
			if (!free_c[i]) top_c = (BW+1)'(WORD_BITS - 1 - i);
		end
		pw_c[0] = free_c;
		for (int j = 1; j <= BW; j++) begin
			pw_c[j] = pw_c[j-1] & (pw_c[j-1] >> (1 << (j - 1)));
		end
		len_small = len_ext <= CNT_W'(WORD_BITS);
		win_c = '1;
		for (int j = 0; j <= BW; j++) begin
			if (len_q[j]) win_c = win_c & (pw_c[j] >> (int'(len_q[BW:0]) & ((1 << j) - 1)));
		end
		pos_c = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (win_c[i]) pos_c = BW'(i);
		end
		win_hit   = len_small && (|win_c) && (|len_q);
		need_c    = len_ext - run_q;
		cmask_c   = low_mask(need_c[BW:0]);
		carry_hit = (run_q != '0) && (need_c <= CNT_W'(WORD_BITS))
			&& ((free_c & cmask_c) == cmask_c);
	end

	always_comb begin
		span_c   = (BW+1)'(WORD_BITS) - {1'b0, mark_b_q};
		take_c   = (left_q < CNT_W'(span_c)) ? left_q[BW:0] : span_c;
		fr_bit_c = {{(WORD_BITS-1){1'b0}}, 1'b1} << fr_b_q;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: begin
				rd_en = in_accept;
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = cur_q + AW'(1);
			end
			S_MARK_RD: begin
				rd_en   = 1'b1;
				rd_addr = mark_w_q;
			end
			S_MARK_WR: begin
				wr_en   = 1'b1;
				wr_addr = mark_w_q;
				wr_data = rdata_q | (low_mask(take_c) << mark_b_q);
				rd_en   = left_q != CNT_W'(take_c);
				rd_addr = mark_w_q + AW'(1);
			end
			S_FR_RD: begin
				rd_en   = 1'b1;
				rd_addr = fr_w_q;
			end
			S_FR_WR: begin
				wr_en   = 1'b1;
				wr_addr = fr_w_q;
				wr_data = set_q ? (rdata_q | fr_bit_c) : (rdata_q & ~fr_bit_c);
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) bitmap_mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= bitmap_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RESET;
		end else if (cfg_we) begin
			total_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (resp_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WORD_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_accept) begin
						len_q       <= run_length;
						set_q       <= (action == ACT_RESERVE);
						res_first_q <= '0;
						cur_q       <= '0;
						base_q      <= '0;
						run_q       <= '0;
						fr_w_q      <= AW'(frame >> BW);
						fr_b_q      <= frame[BW-1:0];
						unique case (action)
							ACT_ALLOC: begin
								if (run_length == '0) begin
									res_status_q <= STAT_BAD;
									state_q      <= S_RESP;
								end else if (limit_c == '0) begin
									res_status_q <= STAT_NOSPACE;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= STAT_BAD;
									state_q      <= S_SCAN;
								end
							end
							ACT_FREE, ACT_RESERVE: begin
								res_status_q <= STAT_BAD;
								if (CNT_W'(frame) < CNT_W'(FRAME_COUNT)) state_q <= S_FR_RD;
								else state_q <= S_RESP;
							end
							default: begin
								res_status_q <= STAT_BAD;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (carry_hit) begin
						mark_w_q     <= st_w_q;
						mark_b_q     <= st_b_q;
						left_q       <= len_ext;
						res_first_q  <= st_f_q[FRAME_W-1:0];
						res_status_q <= STAT_DONE;
						state_q      <= S_MARK_RD;
					end else if (win_hit) begin
						mark_w_q     <= cur_q;
						mark_b_q     <= pos_c;
						left_q       <= len_ext;
						res_first_q  <= FRAME_W'(base_q + CNT_W'(pos_c));
						res_status_q <= STAT_DONE;
						state_q      <= S_MARK_RD;
					end else if (last_c) begin
						res_status_q <= STAT_NOSPACE;
						state_q      <= S_RESP;
					end else begin
						if (full_c) begin
							run_q <= run_q + CNT_W'(WORD_BITS);
							if (run_q == '0) begin
								st_f_q <= base_q;
								st_w_q <= cur_q;
								st_b_q <= '0;
							end
						end else begin
							run_q  <= CNT_W'(top_c);
							st_f_q <= base_q + CNT_W'(WORD_BITS) - CNT_W'(top_c);
							st_w_q <= cur_q;
							st_b_q <= BW'((BW+1)'(WORD_BITS) - top_c);
						end
						cur_q  <= cur_q + AW'(1);
						base_q <= base_q + CNT_W'(WORD_BITS);
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					left_q   <= left_q - CNT_W'(take_c);
					mark_b_q <= '0;
					mark_w_q <= mark_w_q + AW'(1);
					if (left_q == CNT_W'(take_c)) state_q <= S_RESP;
				end
				S_FR_RD: begin
					state_q <= S_FR_WR;
				end
				S_FR_WR: begin
					res_status_q <= STAT_DONE;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (resp_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			first_q  <= res_first_q;
			status_q <= res_status_q;
		end
	end

	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("bitmap read and write hit the same word");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RESP))
		else $error("result word raised outside response");

	a_fail_zero_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != STAT_DONE)) |-> (first_q == '0))
		else $error("failed request carries a frame number");

	a_mark_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK_WR) |-> (left_q != '0) && (take_c != '0))
		else $error("run write-back with nothing left");

endmodule

@@ tb/tb_bitmap_frame_allocator_top.sv @@
module tb_bitmap_frame_allocator_top;
	import bfa_pkg::*;

	localparam int          FRAMES      = 65536;
	localparam logic [1:0]  ACT_UNDEF   = 2'd3;
	localparam int          IDLE_PCT    = 32;
	localparam int          HOLD_AT     = 50;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 4200;
	localparam longint      CYCLE_LIMIT = 6000000;

	typedef struct packed {
		logic [1:0]         kind;
		logic [RUN_W-1:0]   count;
		logic [FRAME_W-1:0] frame_no;
	} frame_req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] first;
		logic [1:0]         code;
	} frame_reply_t;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic [TOTAL_W-1:0] cfg_wdata  = '0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [1:0]         action     = ACT_ALLOC;
	logic [RUN_W-1:0]   run_length = '0;
	logic [FRAME_W-1:0] frame      = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [FRAME_W-1:0] first_frame;
	logic [1:0]         status;

	bitmap_frame_allocator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.run_length (run_length),
		.frame      (frame),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.first_frame(first_frame),
		.status     (status)
	);

	bit [FRAMES-1:0]    used_map       = '0;
	logic [TOTAL_W-1:0] managed_frames = TOTAL_RESET;

	frame_req_t   frame_requests [$];
	frame_reply_t replies_due [$];
	frame_req_t   offered;
	frame_reply_t granted;
	frame_reply_t wanted;

	int     words_loaded   = 0;
	int     words_taken    = 0;
	int     replies_seen   = 0;
	int     faults         = 0;
	int     n_placed       = 0;
	int     n_full         = 0;
	int     n_rejected     = 0;
	int     n_freed        = 0;
	int     n_reserved     = 0;
	int     n_settings     = 0;
	int     hold_left      = 0;
	bit     held           = 1'b0;
	bit     calm           = 1'b0;
	longint cycles         = 0;

	function automatic frame_reply_t frame_map_step(input frame_req_t r);
		frame_reply_t res;
		int unsigned  limit;
		int unsigned  run;
		int unsigned  start;
		int unsigned  f;
		int unsigned  k;
		res.first = '0;
		res.code  = STAT_BAD;
		case (r.kind)
			ACT_ALLOC: begin
				if (r.count == 0)
					return res;
				limit = (managed_frames > FRAMES) ? FRAMES : managed_frames;
				run   = 0;
				start = 0;
				for (f = 0; f < limit; f++) begin
					if (used_map[f]) begin
						run = 0;
					end else begin
						if (run == 0)
							start = f;
						run++;
						if (run == r.count) begin
							for (k = start; k <= f; k++)
								used_map[k] = 1'b1;
							res.first = FRAME_W'(start);
							res.code  = STAT_DONE;
							return res;
						end
					end
				end
				res.code = STAT_NOSPACE;
			end
			ACT_FREE: begin
				used_map[r.frame_no] = 1'b0;
				res.code = STAT_DONE;
			end
			ACT_RESERVE: begin
				used_map[r.frame_no] = 1'b1;
				res.code = STAT_DONE;
			end
			default: res.code = STAT_BAD;
		endcase
		return res;
	endfunction

	function automatic frame_req_t make_req(input logic [1:0] k, input int unsigned n,
			input int unsigned fr);
		frame_req_t r;
		r.kind     = k;
		r.count    = RUN_W'(n);
		r.frame_no = FRAME_W'(fr);
		return r;
	endfunction

	function automatic frame_req_t random_request(input int unsigned span);
		frame_req_t  r;
		int unsigned area;
		int unsigned pick;
		int unsigned roll;
		area       = (span == 0) ? 64 : ((span > 2048) ? 2048 : span);
		pick       = $urandom_range(99);
		roll       = $urandom_range(99);
		r.count    = RUN_W'($urandom);
		r.frame_no = FRAME_W'($urandom);
		if (pick < 48) begin
			r.kind = ACT_ALLOC;
			if (roll < 3)
				r.count = '0;
			else if (roll < 6)
				r.count = RUN_W'($urandom);
			else if (roll < 70)
				r.count = RUN_W'($urandom_range(1, 8));
			else if (roll < 92)
				r.count = RUN_W'($urandom_range(1, 48));
			else
				r.count = RUN_W'($urandom_range(1, area / 2 + 1));
		end else if (pick < 76) begin
			r.kind = ACT_FREE;
			if (roll < 85)
				r.frame_no = FRAME_W'($urandom_range(0, area - 1));
		end else if (pick < 96) begin
			r.kind = ACT_RESERVE;
			if (roll < 85)
				r.frame_no = FRAME_W'($urandom_range(0, area - 1));
		end else begin
			r.kind = ACT_UNDEF;
		end
		return r;
	endfunction

	task automatic note_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endtask

	task automatic wait_drained();
		while (frame_requests.size() != 0 || words_loaded != words_taken ||
				replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_total(input logic [TOTAL_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		managed_frames = v;
		n_settings++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still due", cycles, replies_due.size());
			$display("tb_bitmap_frame_allocator_top NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				granted = frame_map_step(offered);
				replies_due.push_back(granted);
				words_taken++;
				case (offered.kind)
					ACT_ALLOC: begin
						if (granted.code == STAT_DONE)
							n_placed++;
						else if (granted.code == STAT_NOSPACE)
							n_full++;
						else
							n_rejected++;
					end
					ACT_FREE:    n_freed++;
					ACT_RESERVE: n_reserved++;
					default:     n_rejected++;
				endcase
			end
			// hold the word until it is taken
			if (!in_valid || !in_stall) begin
				if (frame_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					offered = frame_requests.pop_front();
					words_loaded++;
					in_valid   <= 1'b1;
					action     <= offered.kind;
					run_length <= offered.count;
					frame      <= offered.frame_no;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					note_fault($sformatf("unexpected reply: first_frame %0d status %0d",
						first_frame, status));
				end else begin
					wanted = replies_due.pop_front();
					if (first_frame !== wanted.first)
						note_fault($sformatf("reply %0d first_frame: expected %0d, got %0d",
							replies_seen, wanted.first, first_frame));
					if (status !== wanted.code)
						note_fault($sformatf("reply %0d status: expected %0d, got %0d",
							replies_seen, wanted.code, status));
				end
				replies_seen++;
			end
			// back off for a long stretch once, so the block fills up
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!held && replies_seen >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin
		int          p;
		int          i;
		int unsigned span;
		int unsigned count;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		frame_requests.push_back(make_req(ACT_ALLOC, 0, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 1, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 3, 0));
		frame_requests.push_back(make_req(ACT_RESERVE, 0, 65535));
		frame_requests.push_back(make_req(ACT_RESERVE, 0, 5));
		frame_requests.push_back(make_req(ACT_ALLOC, 2, 0));
		frame_requests.push_back(make_req(ACT_RESERVE, 0, 5));
		frame_requests.push_back(make_req(ACT_FREE, 0, 4));
		frame_requests.push_back(make_req(ACT_FREE, 0, 2));
		frame_requests.push_back(make_req(ACT_ALLOC, 1, 0));
		frame_requests.push_back(make_req(ACT_UNDEF, 17'h1FFFF, 16'hFFFF));
		frame_requests.push_back(make_req(ACT_ALLOC, 65536, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 17'h1FFFF, 0));
		frame_requests.push_back(make_req(ACT_FREE, 0, 65535));
		frame_requests.push_back(make_req(ACT_ALLOC, 40, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 24, 0));
		frame_requests.push_back(make_req(ACT_FREE, 0, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 2, 0));
		frame_requests.push_back(make_req(ACT_RESERVE, 0, 100));
		frame_requests.push_back(make_req(ACT_ALLOC, 60, 0));

		set_total(0);
		frame_requests.push_back(make_req(ACT_ALLOC, 1, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 0, 0));
		frame_requests.push_back(make_req(ACT_RESERVE, 0, 40000));

		set_total(1);
		frame_requests.push_back(make_req(ACT_ALLOC, 1, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 1, 0));
		frame_requests.push_back(make_req(ACT_FREE, 0, 0));

		for (p = 0; p < 6; p++) begin
			case (p)
				0:       begin span = 300;    count = 60; end
				1:       begin span = 65536;  count = 50; end
				2:       begin span = 40;     count = 40; end
				3:       begin span = 1000;   count = 50; end
				4:       begin span = 131071; count = 40; end
				default: begin span = 97;     count = 30; end
			endcase
			set_total(TOTAL_W'(span));
			calm = (p == 1);
			for (i = 0; i < count; i++)
				frame_requests.push_back(random_request(span));
		end
		wait_drained();
		calm = 1'b0;

		set_total(TOTAL_RESET);
		frame_requests.push_back(make_req(ACT_ALLOC, 20000, 0));
		frame_requests.push_back(make_req(ACT_ALLOC, 65536, 0));

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (replies_due.size() != 0)
			note_fault($sformatf("%0d replies never arrived", replies_due.size()));
		$display("allocations placed %0d, refused for space %0d, rejected requests %0d",
			n_placed, n_full, n_rejected);
		$display("frees %0d, reserves %0d, %0d words over %0d frame-count settings, %0d faults",
			n_freed, n_reserved, words_taken, n_settings, faults);
		if (faults == 0)
			$display("tb_bitmap_frame_allocator_top OK");
		else
			$display("tb_bitmap_frame_allocator_top NOT OK");
		$finish;
	end

endmodule
